// ===== src/assert_macros.svh =====
// Assertion macros shared by the quoted field splitter RTL.
// No dependencies; the macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define QFS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("quoted field splitter assertion failed");
// Condition must never be seen outside reset.
`define QFS_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("quoted field splitter forbidden condition seen");
`else
`define QFS_ASSERT(label, clk, rst_n, prop)
`define QFS_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== src/qfs_pkg.sv =====
// Package of the quoted field splitter: byte codes, register indexes, result type.
// No dependencies.
package qfs_pkg;

    // Fixed character codes.
    localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
    localparam logic [7:0] CR_BYTE        = 8'h0D;
    localparam logic [7:0] LF_BYTE        = 8'h0A;
    localparam logic [7:0] NUL_BYTE       = 8'h00;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;

    // Configuration register indexes.
    localparam logic [7:0] REG_SEPARATOR   = 8'd0;
    localparam logic [7:0] REG_OPEN_QUOTE  = 8'd1;
    localparam logic [7:0] REG_CLOSE_QUOTE = 8'd2;
    localparam logic [7:0] REG_FIELD_LIMIT = 8'd3;

    // Configuration reset values.
    localparam logic [7:0] SEPARATOR_RESET   = 8'd44;
    localparam logic [7:0] OPEN_QUOTE_RESET  = 8'd34;
    localparam logic [7:0] CLOSE_QUOTE_RESET = 8'd34;
    localparam logic [7:0] FIELD_LIMIT_RESET = 8'd0;

    // One result transaction.
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       field_done;
        logic       line_done;
        logic [7:0] fields_so_far;
    } t_result;

endpackage

// ===== src/qfs_out_buf.sv =====
// Two-entry output buffer (output register plus skid stage) for result transactions.
// Depends on qfs_pkg for the result type.
module qfs_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  qfs_pkg::t_result i_data,
    input  logic             i_stall,
    output logic             o_full,
    output logic             o_valid,
    output qfs_pkg::t_result o_data
);

    logic             r_out_valid;
    logic             r_skid_valid;
    qfs_pkg::t_result r_out_data;
    qfs_pkg::t_result r_skid_data;
    logic             out_free;

    // The output register may load when empty or when its transaction leaves.
    assign out_free = !r_out_valid || !i_stall;

    // Control: a push only arrives while the skid stage is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_push) begin
            r_skid_data <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

// ===== src/quoted_field_splitter_top.sv =====
// Top level of the quoted field splitter: configuration registers, parser and output.
// Depends on qfs_pkg, qfs_out_buf and assert_macros.svh.
//
// Usage:
//   Input channel: one byte of a text line per transaction on i_in_byte,
//   accepted when i_in_valid is high and o_in_stall is low.
//   Output channel: at most one result per input byte (kept character, field
//   end, line end with the running field count), taken when o_out_valid is
//   high and i_out_stall is low. Dropped quotes, backslashes, empty fields and
//   bytes after the field limit give no result.
//   Configuration: write i_cfg_data to register i_cfg_index while i_cfg_valid
//   is high; o_cfg_ready is always high. Index 0 separator, 1 open quote,
//   2 close quote, 3 field limit. Other indexes are ignored. Write while idle.
// Timing:
//   The parser decides each byte in the cycle of acceptance; the result is
//   registered in the output register, or in the skid stage while the
//   receiver stalls, and one byte is accepted every cycle while o_in_stall
//   is low. The rate is set by the update of the line state flags and counter.
// Reset and stall:
//   Reset clears the line state and loads the register defaults. When the
//   receiver stalls, results collect in a two-entry buffer; o_in_stall rises
//   only once both entries hold a result.
module quoted_field_splitter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_byte_valid,
    output logic [7:0] o_out_byte,
    output logic       o_field_done,
    output logic       o_line_done,
    output logic [7:0] o_fields_so_far,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    `include "assert_macros.svh"

    // Configuration registers.
    logic [7:0] r_separator;
    logic [7:0] r_open_quote;
    logic [7:0] r_close_quote;
    logic [7:0] r_field_limit;

    // Line state.
    logic       r_quoted, n_quoted;
    logic       r_escape, n_escape;
    logic       r_has_chars, n_has_chars;
    logic [7:0] r_count, n_count;
    logic       r_discard, n_discard;

    logic             in_accept;
    logic             buf_full;
    logic             push;
    logic             is_term;
    logic [7:0]       count_inc;
    logic             limit_hit;
    qfs_pkg::t_result res;
    qfs_pkg::t_result out_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = buf_full;
    assign in_accept   = i_in_valid && !buf_full;

    // Register writes; unknown indexes fall through without effect.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separator   <= qfs_pkg::SEPARATOR_RESET;
            r_open_quote  <= qfs_pkg::OPEN_QUOTE_RESET;
            r_close_quote <= qfs_pkg::CLOSE_QUOTE_RESET;
            r_field_limit <= qfs_pkg::FIELD_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qfs_pkg::REG_SEPARATOR:   r_separator   <= i_cfg_data;
                qfs_pkg::REG_OPEN_QUOTE:  r_open_quote  <= i_cfg_data;
                qfs_pkg::REG_CLOSE_QUOTE: r_close_quote <= i_cfg_data;
                qfs_pkg::REG_FIELD_LIMIT: r_field_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Shared helpers: terminator detect and saturating field count.
    assign is_term = (i_in_byte == qfs_pkg::NUL_BYTE) || (i_in_byte == qfs_pkg::CR_BYTE) ||
                     (i_in_byte == qfs_pkg::LF_BYTE);
    assign count_inc = (r_count != qfs_pkg::COUNT_MAX) ? r_count + 8'd1 : r_count;
    assign limit_hit = (r_field_limit != 8'd0) && (count_inc >= r_field_limit);

    // Per-byte decision, in priority order: discard, terminator, literal,
    // separator, backslash, open quote, close quote, ordinary byte.
    always_comb begin
        n_quoted    = r_quoted;
        n_escape    = r_escape;
        n_has_chars = r_has_chars;
        n_count     = r_count;
        n_discard   = r_discard;
        push        = 1'b0;
        res         = '0;
        res.fields_so_far = r_count;
        if (r_discard) begin
            if (is_term) begin
                n_quoted    = 1'b0;
                n_escape    = 1'b0;
                n_has_chars = 1'b0;
                n_count     = 8'd0;
                n_discard   = 1'b0;
            end
        end else if (is_term) begin
            push              = 1'b1;
            res.line_done     = 1'b1;
            res.field_done    = r_has_chars;
            res.fields_so_far = r_has_chars ? count_inc : r_count;
            n_quoted    = 1'b0;
            n_escape    = 1'b0;
            n_has_chars = 1'b0;
            n_count     = 8'd0;
            n_discard   = 1'b0;
        end else if (r_escape) begin
            n_escape       = 1'b0;
            n_has_chars    = 1'b1;
            push           = 1'b1;
            res.byte_valid = 1'b1;
            res.out_byte   = i_in_byte;
        end else if ((i_in_byte == r_separator) && !r_quoted) begin
            if (r_has_chars) begin
                push              = 1'b1;
                res.field_done    = 1'b1;
                res.fields_so_far = count_inc;
                n_count           = count_inc;
                n_has_chars       = 1'b0;
                if (limit_hit) begin
                    res.line_done = 1'b1;
                    n_quoted      = 1'b0;
                    n_escape      = 1'b0;
                    n_discard     = 1'b1;
                end
            end
        end else if (i_in_byte == qfs_pkg::BACKSLASH_BYTE) begin
            n_escape = 1'b1;
        end else if (!r_quoted && (i_in_byte == r_open_quote)) begin
            n_quoted = 1'b1;
        end else if (r_quoted && (i_in_byte == r_close_quote)) begin
            n_quoted = 1'b0;
        end else begin
            n_has_chars    = 1'b1;
            push           = 1'b1;
            res.byte_valid = 1'b1;
            res.out_byte   = i_in_byte;
        end
    end

    // Line state advances on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoted    <= 1'b0;
            r_escape    <= 1'b0;
            r_has_chars <= 1'b0;
            r_count     <= 8'd0;
            r_discard   <= 1'b0;
        end else if (in_accept) begin
            r_quoted    <= n_quoted;
            r_escape    <= n_escape;
            r_has_chars <= n_has_chars;
            r_count     <= n_count;
            r_discard   <= n_discard;
        end
    end

    // Result buffer towards the receiver.
    qfs_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept && push),
        .i_data  (res),
        .i_stall (i_out_stall),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .o_data  (out_data)
    );

    assign o_byte_valid    = out_data.byte_valid;
    assign o_out_byte      = out_data.out_byte;
    assign o_field_done    = out_data.field_done;
    assign o_line_done     = out_data.line_done;
    assign o_fields_so_far = out_data.fields_so_far;

    // A kept character never carries a field or line end.
    `QFS_NEVER(a_char_no_end, i_clk, i_rst_n, o_out_valid && o_byte_valid && (o_field_done || o_line_done))
    // A field end always reports at least one field.
    `QFS_ASSERT(a_done_counts, i_clk, i_rst_n, (o_out_valid && o_field_done) |-> (o_fields_so_far != 8'd0))
    // While discarding, quote and escape state stay cleared.
    `QFS_ASSERT(a_discard_clean, i_clk, i_rst_n, r_discard |-> (!r_quoted && !r_escape))
    // A pending literal is consumed by the next accepted byte.
    `QFS_ASSERT(a_escape_used, i_clk, i_rst_n, (in_accept && r_escape && !r_discard) |=> !r_escape)

endmodule

// ===== dv/tb_quoted_field_splitter_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of quoted_field_splitter_top: directed and random text lines,
// random idling on both channels, and a field-splitting model in a small scoreboard class.
// Depends on qfs_pkg and the quoted field splitter RTL.

// Tracks the line state of the splitter and holds the results that it should produce.
class field_split_tracker;
    logic [7:0] sep_char;
    logic [7:0] open_q;
    logic [7:0] close_q;
    logic [7:0] limit;

    logic       in_quotes;
    logic       escaped;
    logic       field_open;
    logic [7:0] field_count;
    logic       skipping_line;

    qfs_pkg::t_result expected_q[$];
    int               errors;
    int               compared;
    int               lines_ended;
    int               limit_stops;
    int               peak_count;

    function new();
        sep_char = qfs_pkg::SEPARATOR_RESET;
        open_q   = qfs_pkg::OPEN_QUOTE_RESET;
        close_q  = qfs_pkg::CLOSE_QUOTE_RESET;
        limit    = qfs_pkg::FIELD_LIMIT_RESET;
        clear_line();
    endfunction

    function void clear_line();
        in_quotes     = 1'b0;
        escaped       = 1'b0;
        field_open    = 1'b0;
        field_count   = '0;
        skipping_line = 1'b0;
    endfunction

    // Closes a nonempty field; returns 1 when a nonzero limit has been reached.
    function logic close_field();
        if (field_count != qfs_pkg::COUNT_MAX) begin
            field_count++;
        end
        if (field_count > peak_count) begin
            peak_count = field_count;
        end
        field_open = 1'b0;
        return (limit != 0) && (field_count >= limit);
    endfunction

    function void set_register(logic [7:0] index, logic [7:0] value);
        case (index)
            qfs_pkg::REG_SEPARATOR:   sep_char = value;
            qfs_pkg::REG_OPEN_QUOTE:  open_q   = value;
            qfs_pkg::REG_CLOSE_QUOTE: close_q  = value;
            qfs_pkg::REG_FIELD_LIMIT: limit    = value;
            default: ;
        endcase
    endfunction

    // Works out what one accepted byte produces, if anything.
    function void note_byte(logic [7:0] c);
        qfs_pkg::t_result r;
        logic             is_term;
        logic             stop;
        r       = '0;
        is_term = (c == qfs_pkg::NUL_BYTE) || (c == qfs_pkg::CR_BYTE) ||
                  (c == qfs_pkg::LF_BYTE);

        // After the limit, everything up to the terminator is swallowed.
        if (skipping_line) begin
            if (is_term) begin
                clear_line();
            end
            return;
        end

        // A terminator always ends the line, even straight after a backslash.
        if (is_term) begin
            if (field_open) begin
                void'(close_field());
                r.field_done = 1'b1;
            end
            r.line_done     = 1'b1;
            r.fields_so_far = field_count;
            expected_q.push_back(r);
            lines_ended++;
            clear_line();
            return;
        end

        // The byte after a backslash is kept whatever it is.
        if (escaped) begin
            escaped         = 1'b0;
            field_open      = 1'b1;
            r.byte_valid    = 1'b1;
            r.out_byte      = c;
            r.fields_so_far = field_count;
            expected_q.push_back(r);
            return;
        end

        // Separator outside quotes: an empty field is skipped without a result.
        if (c == sep_char && !in_quotes) begin
            if (!field_open) begin
                return;
            end
            stop            = close_field();
            r.field_done    = 1'b1;
            r.line_done     = stop;
            r.fields_so_far = field_count;
            if (stop) begin
                in_quotes     = 1'b0;
                escaped       = 1'b0;
                skipping_line = 1'b1;
                limit_stops++;
            end
            expected_q.push_back(r);
            return;
        end

        // Backslash and quote bytes are dropped.
        if (c == qfs_pkg::BACKSLASH_BYTE) begin
            escaped = 1'b1;
            return;
        end
        if (!in_quotes && c == open_q) begin
            in_quotes = 1'b1;
            return;
        end
        if (in_quotes && c == close_q) begin
            in_quotes = 1'b0;
            return;
        end

        field_open      = 1'b1;
        r.byte_valid    = 1'b1;
        r.out_byte      = c;
        r.fields_so_far = field_count;
        expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(qfs_pkg::t_result got);
        qfs_pkg::t_result want;
        if (expected_q.size() == 0) begin
            $error("result with nothing expected: out_byte %0d, line_done %0d",
                   got.out_byte, got.line_done);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        compared++;
        compare_field("byte_valid", want.byte_valid, got.byte_valid);
        compare_field("out_byte", want.out_byte, got.out_byte);
        compare_field("field_done", want.field_done, got.field_done);
        compare_field("line_done", want.line_done, got.line_done);
        compare_field("fields_so_far", want.fields_so_far, got.fields_so_far);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_quoted_field_splitter_top;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_in_byte = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_byte_valid;
    logic [7:0] o_out_byte;
    logic       o_field_done;
    logic       o_line_done;
    logic [7:0] o_fields_so_far;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    field_split_tracker tracker = new();
    qfs_pkg::t_result   seen_result;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    logic               hold_request = 1'b0;
    int                 items_sent = 0;
    logic [7:0]         opening_bytes[$];
    logic [7:0]         limit_bytes[$];

    quoted_field_splitter_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_valid   (o_byte_valid),
        .o_out_byte     (o_out_byte),
        .o_field_done   (o_field_done),
        .o_line_done    (o_line_done),
        .o_fields_so_far(o_fields_so_far),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Watch all three channels at the rising edge; results first, as a result is registered after its byte is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                seen_result.byte_valid    = o_byte_valid;
                seen_result.out_byte      = o_out_byte;
                seen_result.field_done    = o_field_done;
                seen_result.line_done     = o_line_done;
                seen_result.fields_so_far = o_fields_so_far;
                tracker.check_result(seen_result);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.set_register(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                tracker.note_byte(i_in_byte);
            end
        end
    end

    // Receiver: random stalls, and a long hold-off when one is requested.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end
            i_out_stall = ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Offers one byte, with random idle cycles first, until it is taken.
    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_byte  = value;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Leaves valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [7:0] sep, input logic [7:0] oq,
                                  input logic [7:0] cq, input logic [7:0] lim);
        write_reg(qfs_pkg::REG_SEPARATOR, sep);
        write_reg(qfs_pkg::REG_OPEN_QUOTE, oq);
        write_reg(qfs_pkg::REG_CLOSE_QUOTE, cq);
        write_reg(qfs_pkg::REG_FIELD_LIMIT, lim);
        // An index with no register behind it must change nothing.
        write_reg(8'(qfs_pkg::REG_FIELD_LIMIT + 1 + $urandom_range(0, 251)),
                  8'($urandom_range(0, 255)));
        i_cfg_valid = 1'b0;
    endtask

    // Waits until every expected result is out, plus a settling wait for silent bytes.
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One line built mostly from the bytes that matter under the current settings.
    task automatic send_random_line(input int max_len);
        int         len;
        int         pick;
        logic [7:0] c;
        len = $urandom_range(0, max_len);
        repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                c = 8'($urandom_range(8'h61, 8'h7A));
            end else if (pick < 60) begin
                c = tracker.sep_char;
            end else if (pick < 68) begin
                c = tracker.open_q;
            end else if (pick < 76) begin
                c = tracker.close_q;
            end else if (pick < 84) begin
                send_byte(qfs_pkg::BACKSLASH_BYTE);
                c = 8'($urandom_range(0, 255));
            end else begin
                c = 8'($urandom_range(0, 255));
            end
            send_byte(c);
        end
        // Now and then the terminator is escaped, which must still end the line.
        if ($urandom_range(0, 9) == 0) begin
            send_byte(qfs_pkg::BACKSLASH_BYTE);
        end
        pick = $urandom_range(0, 2);
        send_byte(pick == 0 ? qfs_pkg::NUL_BYTE :
                  (pick == 1 ? qfs_pkg::CR_BYTE : qfs_pkg::LF_BYTE));
    endtask

    task automatic run_phase(input logic [7:0] sep, input logic [7:0] oq, input logic [7:0] cq,
                             input logic [7:0] lim, input int idle_pct, input int stall_p,
                             input int budget, input logic with_hold);
        int start;
        wait_idle();
        apply_settings(sep, oq, cq, lim);
        send_idle_pct = idle_pct;
        stall_pct     = stall_p;
        if (with_hold) begin
            hold_request = 1'b1;
        end
        start = items_sent;
        while (items_sent - start < budget) begin
            send_random_line($urandom_range(0, 4) == 0 ? 40 : 10);
        end
    endtask

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        // Default settings: quoted separator, empty and quote-only fields, escapes,
        // an escaped terminator, the top byte value, CR and an empty line on NUL.
        opening_bytes = '{8'h61, 8'h2C, 8'h22, 8'h2C, 8'h22, 8'h62, 8'h2C, 8'h2C, 8'h22,
                          8'h22, 8'h2C, qfs_pkg::BACKSLASH_BYTE, qfs_pkg::LF_BYTE, 8'hFF,
                          qfs_pkg::BACKSLASH_BYTE, qfs_pkg::BACKSLASH_BYTE, qfs_pkg::CR_BYTE,
                          qfs_pkg::NUL_BYTE};
        // "a,b,c" then CR with a limit of two: the line stops early and the rest is dropped.
        limit_bytes = '{8'h61, 8'h2C, 8'h62, 8'h2C, 8'h63, qfs_pkg::CR_BYTE};

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (opening_bytes[k]) send_byte(opening_bytes[k]);
        wait_idle();
        apply_settings(8'h2C, 8'h22, 8'h22, 8'd2);
        foreach (limit_bytes[k]) send_byte(limit_bytes[k]);

        // Default settings, no idling, and a long receiver hold-off to fill the block.
        run_phase(8'h2C, 8'h22, 8'h22, 8'd0, 0, 0, 100, 1'b1);
        // Semicolon and brackets, limit three, sender mostly idle.
        run_phase(8'h3B, 8'h5B, 8'h5D, 8'd3, 70, 0, 100, 1'b0);
        // All-ones and all-zeros codes, limit one, receiver mostly stalled.
        run_phase(8'hFF, 8'h00, 8'hFF, 8'd1, 0, 70, 100, 1'b0);
        // Unusual codes and the largest limit, both sides idling.
        run_phase(8'h7F, 8'hFF, 8'h00, 8'd255, 35, 35, 100, 1'b0);
        // Backslash as separator and a single quote for both quotes, limit two.
        run_phase(qfs_pkg::BACKSLASH_BYTE, 8'h27, 8'h27, 8'd2, 0, 0, 100, 1'b0);

        // Enough fields on one line to saturate the field count, then more random lines.
        wait_idle();
        apply_settings(8'h2C, 8'h22, 8'h22, 8'd0);
        send_idle_pct = 35;
        stall_pct     = 35;
        repeat (257) begin
            send_byte(8'h78);
            send_byte(8'h2C);
        end
        send_byte(qfs_pkg::LF_BYTE);
        run_phase(8'h2C, 8'h22, 8'h22, 8'd0, 35, 35, 100, 1'b0);

        wait_idle();
        $display("Summary: %0d input bytes over several register settings, %0d results compared.",
                 items_sent, tracker.compared);
        $display("Summary: %0d lines ended, %0d stopped at the field limit, peak count %0d.",
                 tracker.lines_ended, tracker.limit_stops, tracker.peak_count);
        if (tracker.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/qfs_pkg.sv
src/qfs_out_buf.sv
src/quoted_field_splitter_top.sv
dv/tb_quoted_field_splitter_top.sv
